FILE: src/itrs_pkg.sv
`timescale 1ns / 1ps
// itrs_pkg: types, constants and helpers shared by the int_to_radix_string block.
// No dependencies.
package itrs_pkg;

   localparam int DIVIDEND_W = 32;
   localparam int DIV_BITS   = 8;
   localparam int DIV_STEPS  = DIVIDEND_W / DIV_BITS;
   localparam int STEP_W     = $clog2(DIV_STEPS);

   localparam logic [7:0] BASE_MIN   = 8'd2;
   localparam logic [7:0] BASE_MAX   = 8'd16;
   localparam logic [3:0] DEC_MAX    = 4'd9;
   localparam logic [3:0] DEC_COUNT  = 4'd10;
   localparam logic [6:0] ASCII_ZERO = 7'h30;
   localparam logic [6:0] ASCII_A    = 7'h41;

   typedef struct packed {
      logic signed [31:0] num;
      logic        [7:0]  base;
   } req_type;

   typedef struct packed {
      logic [6:0] char_code;
      logic       has_char;
      logic       last;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIV,
      ST_READ,
      ST_EMIT,
      ST_SPECIAL
   } state_type;

   typedef enum logic [1:0] {
      OUT_DIGIT,
      OUT_BAD_BASE,
      OUT_EMPTY
   } out_kind_type;

   typedef struct packed {
      logic         load;
      logic         div_step;
      logic         pop;
      logic         out_load;
      out_kind_type out_kind;
   } cmd_type;

   typedef struct packed {
      logic base_bad;
      logic num_empty;
      logic div_stop;
      logic count_zero;
      logic out_free;
   } status_type;

   function automatic logic [6:0] digit_char(input logic [3:0] d);
      logic [6:0] c;
      if (d > DEC_MAX) begin
         c = ASCII_A + {3'b000, d - DEC_COUNT};
      end else begin
         c = ASCII_ZERO + {3'b000, d};
      end
      return c;
   endfunction

endpackage

FILE: src/itrs_ctrl.sv
`timescale 1ns / 1ps
// itrs_ctrl: sequencing state machine for the radix conversion.
// Depends on itrs_pkg; drives itrs_dp through cmd_type / status_type.
module itrs_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  itrs_pkg::status_type status,
   output itrs_pkg::cmd_type    cmd
);
   import itrs_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      req_ready    = 1'b0;
      cmd.load     = 1'b0;
      cmd.div_step = 1'b0;
      cmd.pop      = 1'b0;
      cmd.out_load = 1'b0;
      cmd.out_kind = OUT_DIGIT;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.base_bad || status.num_empty) begin
               state_in = ST_SPECIAL;
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_stop) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            cmd.pop  = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_kind = OUT_DIGIT;
               state_in     = status.count_zero ? ST_IDLE : ST_READ;
            end
         end
         ST_SPECIAL: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_kind = status.base_bad ? OUT_BAD_BASE : OUT_EMPTY;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

FILE: src/itrs_dp.sv
`timescale 1ns / 1ps
// itrs_dp: divider (8 quotient bits per cycle), digit stack memory and result register.
// Depends on itrs_pkg; controlled by itrs_ctrl.
module itrs_dp #(
   parameter int MAX_DIGITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  itrs_pkg::req_type    req_data,
   input  itrs_pkg::cmd_type    cmd,
   output itrs_pkg::status_type status,
   output itrs_pkg::rsp_type    rsp_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready
);
   import itrs_pkg::*;

   localparam int AW = $clog2(MAX_DIGITS);
   localparam int CW = $clog2(MAX_DIGITS + 1);

   logic [3:0]            digit_mem [MAX_DIGITS];
   logic [3:0]            rd_data_ff;
   logic [4:0]            base_ff;
   logic                  base_bad_ff;
   logic                  num_empty_ff;
   logic [DIVIDEND_W-1:0] quot_ff;
   logic [3:0]            rem_ff;
   logic [STEP_W-1:0]     step_ff;
   logic [CW-1:0]         count_ff;
   rsp_type               rsp_ff;
   logic                  rsp_valid_ff;

   logic [DIVIDEND_W-1:0] quot_in;
   logic [3:0]            rem_in;
   logic [4:0]            partial;
   logic                  last_step;
   logic [CW-1:0]         count_inc;
   logic [CW-1:0]         count_dec;
   logic                  out_free;

   // restoring division, DIV_BITS quotient bits per cycle; remainder stays below base
   always_comb begin
      rem_in  = rem_ff;
      quot_in = quot_ff;
      partial = '0;
      for (int i = 0; i < DIV_BITS; i++) begin
         partial = {rem_in, quot_in[DIVIDEND_W-1]};
         quot_in = {quot_in[DIVIDEND_W-2:0], 1'b0};
         if (partial >= base_ff) begin
            rem_in     = 4'(partial - base_ff);
            quot_in[0] = 1'b1;
         end else begin
            rem_in = partial[3:0];
         end
      end
   end

   assign last_step = (step_ff == STEP_W'(DIV_STEPS - 1));
   assign count_inc = count_ff + 1'b1;
   assign count_dec = count_ff - 1'b1;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign status.base_bad   = base_bad_ff;
   assign status.num_empty  = num_empty_ff;
   assign status.div_stop   = last_step &&
                              ((quot_in == '0) || (count_inc == CW'(MAX_DIGITS)));
   assign status.count_zero = (count_ff == '0);
   assign status.out_free   = out_free;

   assign rsp_data  = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.load) begin
            step_ff  <= '0;
            count_ff <= '0;
         end else if (cmd.div_step) begin
            step_ff <= step_ff + 1'b1;
            if (last_step) begin
               count_ff <= count_inc;
            end
         end else if (cmd.pop) begin
            count_ff <= count_dec;
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         base_ff      <= req_data.base[4:0];
         base_bad_ff  <= (req_data.base < BASE_MIN) || (req_data.base > BASE_MAX);
         num_empty_ff <= req_data.num[31] || (req_data.num == '0);
         quot_ff      <= {1'b0, req_data.num[30:0]};
         rem_ff       <= '0;
      end else if (cmd.div_step) begin
         quot_ff <= quot_in;
         rem_ff  <= last_step ? 4'd0 : rem_in;
      end
      if (cmd.out_load) begin
         case (cmd.out_kind)
            OUT_DIGIT: begin
               rsp_ff.char_code <= digit_char(rd_data_ff);
               rsp_ff.has_char  <= 1'b1;
               rsp_ff.last      <= (count_ff == '0);
            end
            OUT_BAD_BASE: begin
               rsp_ff.char_code <= ASCII_ZERO;
               rsp_ff.has_char  <= 1'b1;
               rsp_ff.last      <= 1'b1;
            end
            default: begin
               rsp_ff.char_code <= '0;
               rsp_ff.has_char  <= 1'b0;
               rsp_ff.last      <= 1'b1;
            end
         endcase
      end
   end

   // digit stack
   always_ff @(posedge clock) begin
      if (cmd.div_step && last_step) begin
         digit_mem[count_ff[AW-1:0]] <= rem_in;
      end
      if (cmd.pop) begin
         rd_data_ff <= digit_mem[count_dec[AW-1:0]];
      end
   end

endmodule

FILE: src/int_to_radix_string.sv
`timescale 1ns / 1ps
// int_to_radix_string: top level, converts a signed 32-bit value to ASCII digits in base 2..16.
// Depends on itrs_pkg, itrs_ctrl, itrs_dp.
//
// One request transfer yields a string of rsp transfers, most significant digit first,
// the final one marked by last. A base outside 2..16 yields the single character '0';
// otherwise a value of zero or below yields one transfer with has_char low. One request is
// handled at a time: a conversion accepts and checks the request, then divides (8 quotient
// bits per cycle), pushing each digit on the digit stack, then pops the digits one by one
// into the result register, waiting while the rsp side applies back-pressure; a result holds
// at most 31 digits (base 2). Special cases go from the check straight to loading the
// result register. The result register lets a new request be taken while the final
// character still waits on the rsp side.
module int_to_radix_string #(
   parameter int MAX_DIGITS = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  itrs_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output itrs_pkg::rsp_type rsp_data
);
   import itrs_pkg::*;

   cmd_type    cmd;
   status_type status;

   itrs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   itrs_dp #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_data  (rsp_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready)
   );

endmodule

FILE: src/itrs_checker.sv
`timescale 1ns / 1ps
// itrs_checker: port-level assertions for int_to_radix_string, bound to the top level.
// Depends on itrs_pkg and int_to_radix_string.
module itrs_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input itrs_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input itrs_pkg::rsp_type rsp_data
);
   import itrs_pkg::*;

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp changed while stalled");

   a_empty_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.has_char |-> rsp_data.last && (rsp_data.char_code == '0))
      else $error("empty result malformed");

   a_char_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.has_char |->
         ((rsp_data.char_code >= 7'h30) && (rsp_data.char_code <= 7'h39)) ||
         ((rsp_data.char_code >= 7'h41) && (rsp_data.char_code <= 7'h46)))
      else $error("character outside digit set");

   // a request is only taken when no conversion is in progress
   a_no_accept_mid_string: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last |-> !req_ready)
      else $error("request accepted mid string");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind int_to_radix_string itrs_checker u_itrs_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
